// File: rtl/hbrt_pkg.sv
// ----------------------------------------------------------------------------
// hbrt_pkg
// Shared types, constants and the scan-code table for the boot report tracker.
// ----------------------------------------------------------------------------
package hbrt_pkg;

    localparam int BYTE_W      = 8;
    localparam int POS_W       = 12;
    localparam int LEN_W       = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int KBD_MIN_LEN = 8;
    localparam int MSE_MIN_LEN = 3;

    localparam logic [POS_W-1:0] DEFAULT_WIDTH  = 12'd640;
    localparam logic [POS_W-1:0] DEFAULT_HEIGHT = 12'd480;
    localparam logic [BYTE_W-1:0] SCAN_UNMAPPED = 8'hFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] modifier_bits;
        logic [BYTE_W-1:0] fresh_key;
        logic [BYTE_W-1:0] fresh_key_translated;
    } key_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] button_bits;
        logic [BYTE_W-1:0] delta_x;
        logic [BYTE_W-1:0] delta_y;
        logic [POS_W-1:0]  pointer_x;
        logic [POS_W-1:0]  pointer_y;
    } mouse_result_t;

    // usage code to scan code
    function automatic logic [BYTE_W-1:0] scan_lookup(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] r;
        case (code)
            8'h04: r = 8'h00; 8'h05: r = 8'h0B; 8'h06: r = 8'h08; 8'h07: r = 8'h02;
            8'h08: r = 8'h0E; 8'h09: r = 8'h03; 8'h0A: r = 8'h05; 8'h0B: r = 8'h04;
            8'h0C: r = 8'h22; 8'h0D: r = 8'h26; 8'h0E: r = 8'h28; 8'h0F: r = 8'h25;
            8'h10: r = 8'h2E; 8'h11: r = 8'h2D; 8'h12: r = 8'h1F; 8'h13: r = 8'h23;
            8'h14: r = 8'h0C; 8'h15: r = 8'h0F; 8'h16: r = 8'h01; 8'h17: r = 8'h11;
            8'h18: r = 8'h20; 8'h19: r = 8'h09; 8'h1A: r = 8'h0D; 8'h1B: r = 8'h07;
            8'h1C: r = 8'h10; 8'h1D: r = 8'h06; 8'h1E: r = 8'h12; 8'h1F: r = 8'h13;
            8'h20: r = 8'h14; 8'h21: r = 8'h15; 8'h22: r = 8'h17; 8'h23: r = 8'h16;
            8'h24: r = 8'h1A; 8'h25: r = 8'h1C; 8'h26: r = 8'h19; 8'h27: r = 8'h1D;
            8'h28: r = 8'h24; 8'h29: r = 8'h35; 8'h2A: r = 8'h33; 8'h2B: r = 8'h30;
            8'h2C: r = 8'h31; 8'h2D: r = 8'h1B; 8'h2E: r = 8'h18; 8'h2F: r = 8'h21;
            8'h30: r = 8'h1E; 8'h31: r = 8'h2A; 8'h33: r = 8'h29;
            8'h34: r = 8'h27; 8'h35: r = 8'h32; 8'h36: r = 8'h2B; 8'h37: r = 8'h2F;
            8'h38: r = 8'h2C; 8'h39: r = 8'h39; 8'h3A: r = 8'h7A; 8'h3B: r = 8'h78;
            8'h3C: r = 8'h63; 8'h3D: r = 8'h76; 8'h3E: r = 8'h60; 8'h3F: r = 8'h61;
            8'h40: r = 8'h62; 8'h41: r = 8'h64; 8'h42: r = 8'h65; 8'h43: r = 8'h6D;
            8'h44: r = 8'h67; 8'h45: r = 8'h6F;
            8'h49: r = 8'h72; 8'h4A: r = 8'h73; 8'h4B: r = 8'h74;
            8'h4C: r = 8'h75; 8'h4D: r = 8'h77; 8'h4E: r = 8'h79; 8'h4F: r = 8'h7C;
            8'h50: r = 8'h7B; 8'h51: r = 8'h7D; 8'h52: r = 8'h7E; 8'h53: r = 8'h47;
            8'h54: r = 8'h4B; 8'h55: r = 8'h43; 8'h56: r = 8'h4E; 8'h57: r = 8'h45;
            8'h58: r = 8'h4C; 8'h59: r = 8'h53; 8'h5A: r = 8'h54; 8'h5B: r = 8'h55;
            8'h5C: r = 8'h56; 8'h5D: r = 8'h57; 8'h5E: r = 8'h58; 8'h5F: r = 8'h59;
            8'h60: r = 8'h5B; 8'h61: r = 8'h5C; 8'h62: r = 8'h52; 8'h63: r = 8'h41;
            8'h67: r = 8'h51;
            8'h68: r = 8'h69; 8'h69: r = 8'h6B; 8'h6A: r = 8'h71; 8'h6B: r = 8'h6A;
            8'h6C: r = 8'h40; 8'h6D: r = 8'h4F; 8'h6E: r = 8'h50; 8'h6F: r = 8'h5A;
            8'hE0: r = 8'h3B; 8'hE1: r = 8'h38; 8'hE2: r = 8'h3A; 8'hE3: r = 8'h37;
            8'hE4: r = 8'h3E; 8'hE5: r = 8'h3C; 8'hE6: r = 8'h3D; 8'hE7: r = 8'h36;
            default: r = SCAN_UNMAPPED;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/hbrt_key_tracker.sv
// ----------------------------------------------------------------------------
// hbrt_key_tracker
// Keeps the current and previous keyboard reports and finds the first newly
// pressed key of the updated state, with its scan-code translation.
// ----------------------------------------------------------------------------
module hbrt_key_tracker #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  load,
    input  logic [hbrt_pkg::BYTE_W-1:0]           modifier,
    input  logic [KEY_SLOTS-1:0][hbrt_pkg::BYTE_W-1:0] keys,
    output hbrt_pkg::key_result_t                 result
);
    import hbrt_pkg::*;

    logic [BYTE_W-1:0]                 mod_reg,  mod_next;
    logic [KEY_SLOTS-1:0][BYTE_W-1:0]  cur_reg,  cur_next;
    logic [KEY_SLOTS-1:0][BYTE_W-1:0]  prev_reg, prev_next;
    logic [KEY_SLOTS-1:0]              seen;
    logic [BYTE_W-1:0]                 fresh;

    always_comb
    begin
        mod_next  = mod_reg;
        cur_next  = cur_reg;
        prev_next = prev_reg;
        if (load)
        begin
            mod_next  = modifier;
            cur_next  = keys;
            prev_next = cur_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg  <= '0;
            cur_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            mod_reg  <= mod_next;
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
        end
    end

    // result reflects the state after this word's update
    always_comb
    begin
        seen  = '0;
        fresh = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (prev_next[j] == cur_next[i])
                begin
                    seen[i] = 1'b1;
                end
            end
        end
        for (int i = KEY_SLOTS - 1; i >= 0; i--)
        begin
            if ((cur_next[i] != '0) && !seen[i])
            begin
                fresh = cur_next[i];
            end
        end
    end

    assign result.modifier_bits        = mod_next;
    assign result.fresh_key            = fresh;
    assign result.fresh_key_translated = scan_lookup(fresh);

endmodule

// File: rtl/hbrt_pointer.sv
// ----------------------------------------------------------------------------
// hbrt_pointer
// Holds the last mouse report and the pointer position, clamped to the
// screen bounds.
// ----------------------------------------------------------------------------
module hbrt_pointer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [hbrt_pkg::BYTE_W-1:0]   buttons,
    input  logic [hbrt_pkg::BYTE_W-1:0]   dx,
    input  logic [hbrt_pkg::BYTE_W-1:0]   dy,
    input  logic [hbrt_pkg::POS_W-1:0]    bound_x,
    input  logic [hbrt_pkg::POS_W-1:0]    bound_y,
    output hbrt_pkg::mouse_result_t       result
);
    import hbrt_pkg::*;

    localparam int SUM_W = POS_W + 2;

    logic [BYTE_W-1:0] btn_reg, btn_next;
    logic [BYTE_W-1:0] dx_reg,  dx_next;
    logic [BYTE_W-1:0] dy_reg,  dy_next;
    logic [POS_W-1:0]  px_reg,  px_next;
    logic [POS_W-1:0]  py_reg,  py_next;

    function automatic logic [POS_W-1:0] move_axis(
        input logic [POS_W-1:0]  pos,
        input logic [BYTE_W-1:0] delta,
        input logic [POS_W-1:0]  bound
    );
        logic signed [SUM_W-1:0] sum;
        logic [POS_W-1:0]        r;
        sum = $signed({2'b00, pos}) + $signed({{(SUM_W-BYTE_W){delta[BYTE_W-1]}}, delta});
        if (sum < 0)
        begin
            r = '0;
        end
        else if (sum >= $signed({2'b00, bound}))
        begin
            r = bound - POS_W'(1);
        end
        else
        begin
            r = sum[POS_W-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        btn_next = btn_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        px_next  = px_reg;
        py_next  = py_reg;
        if (load)
        begin
            btn_next = buttons;
            dx_next  = dx;
            dy_next  = dy;
            px_next  = move_axis(px_reg, dx, bound_x);
            py_next  = move_axis(py_reg, dy, bound_y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_reg <= '0;
            dx_reg  <= '0;
            dy_reg  <= '0;
            px_reg  <= '0;
            py_reg  <= '0;
        end
        else
        begin
            btn_reg <= btn_next;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            px_reg  <= px_next;
            py_reg  <= py_next;
        end
    end

    assign result.button_bits = btn_next;
    assign result.delta_x     = dx_next;
    assign result.delta_y     = dy_next;
    assign result.pointer_x   = px_next;
    assign result.pointer_y   = py_next;

endmodule

// File: rtl/hid_boot_report_tracker.sv
// ----------------------------------------------------------------------------
// hid_boot_report_tracker
// Boot-protocol keyboard/mouse report tracker with pointer clamping.
// ----------------------------------------------------------------------------
// One word in, one word out. A report is taken into an input register; once
// the output register is free or being drained, it updates the keyboard or
// pointer state and lands in the output register. A new word is accepted
// every cycle while the output side keeps up; throughput is set by the single
// input-to-output register stage. m_tuser is 1 when the report was long enough
// to update state. Screen size writes take effect on the next mouse report.
module hid_boot_report_tracker #(
    parameter int KEY_SLOTS = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [71:0]                          s_tdata,  // report_length, byte_0..byte_7
    input  logic                                 s_tuser,  // is_mouse
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // modifier_bits, fresh_key, fresh_key_translated, button_bits,
    // delta_x, delta_y, pointer_x, pointer_y
    output logic [71:0]                          m_tdata,
    output logic                                 m_tuser,  // accepted
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hbrt_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [hbrt_pkg::POS_W-1:0]           cfg_data
);
    import hbrt_pkg::*;

    localparam int IN_W = LEN_W + 8 * BYTE_W;

    logic              in_valid_reg;
    logic              in_mouse_reg;
    logic [IN_W-1:0]   in_data_reg;
    logic              out_valid_reg;
    logic              out_user_reg;
    logic [71:0]       out_data_reg;
    logic [POS_W-1:0]  width_reg;
    logic [POS_W-1:0]  height_reg;

    logic              advance;
    logic              s_accept;
    logic [LEN_W-1:0]  len;
    logic [7:0][BYTE_W-1:0] bytes;
    logic [KEY_SLOTS-1:0][BYTE_W-1:0] keys;
    logic              kbd_load;
    logic              mse_load;
    logic [POS_W-1:0]  bound_x;
    logic [POS_W-1:0]  bound_y;
    key_result_t       key_res;
    mouse_result_t     mse_res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign len   = in_data_reg[LEN_W-1:0];
    assign bytes = in_data_reg[IN_W-1:LEN_W];

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            keys[i] = bytes[2 + i];
        end
    end

    assign kbd_load = advance && !in_mouse_reg && (len >= LEN_W'(KBD_MIN_LEN));
    assign mse_load = advance &&  in_mouse_reg && (len >= LEN_W'(MSE_MIN_LEN));
    assign bound_x  = (width_reg  == '0) ? DEFAULT_WIDTH  : width_reg;
    assign bound_y  = (height_reg == '0) ? DEFAULT_HEIGHT : height_reg;

    hbrt_key_tracker #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (kbd_load),
        .modifier (bytes[0]),
        .keys     (keys),
        .result   (key_res)
    );

    hbrt_pointer u_pointer (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (mse_load),
        .buttons (bytes[0]),
        .dx      (bytes[1]),
        .dy      (bytes[2]),
        .bound_x (bound_x),
        .bound_y (bound_y),
        .result  (mse_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= DEFAULT_WIDTH;
            height_reg    <= DEFAULT_HEIGHT;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_mouse_reg <= s_tuser;
            in_data_reg  <= s_tdata[IN_W-1:0];
        end
        if (advance)
        begin
            out_user_reg <= kbd_load || mse_load;
            out_data_reg <= {mse_res.pointer_y, mse_res.pointer_x,
                             mse_res.delta_y, mse_res.delta_x, mse_res.button_bits,
                             key_res.fresh_key_translated, key_res.fresh_key,
                             key_res.modifier_bits};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: verif/hbrt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbrt_checker
// Watches the report, result and screen-size channels of the boot report
// tracker. It predicts every result word from the accepted report words and
// compares it, field by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module hbrt_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [71:0]                      s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [71:0]                      m_tdata,
    input  logic                             m_tuser,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hbrt_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hbrt_pkg::POS_W-1:0]       cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               checked
);
    import hbrt_pkg::*;

    typedef struct {
        logic                     accepted;
        logic [BYTE_W-1:0]        modifier_bits;
        logic [BYTE_W-1:0]        fresh_key;
        logic [BYTE_W-1:0]        fresh_key_translated;
        logic [BYTE_W-1:0]        button_bits;
        logic signed [BYTE_W-1:0] delta_x;
        logic signed [BYTE_W-1:0] delta_y;
        logic [POS_W-1:0]         pointer_x;
        logic [POS_W-1:0]         pointer_y;
    } tracker_view_t;

    // usage codes 0x00..0x6F, first code in the top byte
    localparam logic [8*112-1:0] USAGE_MAP_LOW = {
        128'hFFFFFFFF_000B0802_0E030504_22262825,
        128'h2E2D1F23_0C0F0111_20090D07_10061213,
        128'h14151716_1A1C191D_24353330_311B1821,
        128'h1E2AFF29_27322B2F_2C397A78_63766061,
        128'h6264656D_676FFFFF_FF727374_7577797C,
        128'h7B7D7E47_4B434E45_4C535455_56575859,
        128'h5B5C5241_FFFFFF51_696B716A_404F505A
    };
    // modifier usages 0xE0..0xE7
    localparam logic [63:0] USAGE_MAP_MODS = 64'h3B383A37_3E3C3D36;

    tracker_view_t     expected_views[$];
    logic [POS_W-1:0]  width_reg;
    logic [POS_W-1:0]  height_reg;
    logic [63:0]       kbd_now;
    logic [63:0]       kbd_before;
    logic [BYTE_W-1:0] mouse_buttons;
    logic [BYTE_W-1:0] mouse_dx;
    logic [BYTE_W-1:0] mouse_dy;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;

    function automatic logic [BYTE_W-1:0] translate_usage(input logic [BYTE_W-1:0] code);
        if (code < 8'h70)
            return USAGE_MAP_LOW[8*(111 - int'(code)) +: 8];
        else if (code[7:3] == 5'b11100)
            return USAGE_MAP_MODS[8*(7 - int'(code[2:0])) +: 8];
        return SCAN_UNMAPPED;
    endfunction

    function automatic logic [BYTE_W-1:0] first_new_key(input logic [63:0] now_rep,
                                                       input logic [63:0] old_rep);
        logic [BYTE_W-1:0] key;
        logic              held;
        for (int i = 0; i < 6; i++) begin
            key  = now_rep[16 + 8*i +: 8];
            held = 1'b0;
            for (int j = 0; j < 6; j++)
                if (old_rep[16 + 8*j +: 8] == key)
                    held = 1'b1;
            if (key != 8'h00 && !held)
                return key;
        end
        return 8'h00;
    endfunction

    function automatic logic [POS_W-1:0] step_axis(input logic [POS_W-1:0] pos,
                                                  input logic signed [BYTE_W-1:0] delta,
                                                  input logic [POS_W-1:0] bound_reg,
                                                  input logic [POS_W-1:0] bound_dflt);
        int bound;
        int p;
        bound = (bound_reg == '0) ? int'(bound_dflt) : int'(bound_reg);
        p = int'(pos) + int'(delta);
        if (p < 0)
            p = 0;
        if (p >= bound)
            p = bound - 1;
        return p[POS_W-1:0];
    endfunction

    task automatic track_report(input logic mouse, input logic [LEN_W-1:0] len,
                                input logic [63:0] bytes, output tracker_view_t v);
        v.accepted = 1'b0;
        if (!mouse && len >= KBD_MIN_LEN) begin
            kbd_before = kbd_now;
            kbd_now    = bytes;
            v.accepted = 1'b1;
        end else if (mouse && len >= MSE_MIN_LEN) begin
            mouse_buttons = bytes[7:0];
            mouse_dx      = bytes[15:8];
            mouse_dy      = bytes[23:16];
            pos_x = step_axis(pos_x, $signed(mouse_dx), width_reg, DEFAULT_WIDTH);
            pos_y = step_axis(pos_y, $signed(mouse_dy), height_reg, DEFAULT_HEIGHT);
            v.accepted = 1'b1;
        end
        v.modifier_bits        = kbd_now[7:0];
        v.fresh_key            = first_new_key(kbd_now, kbd_before);
        v.fresh_key_translated = translate_usage(v.fresh_key);
        v.button_bits          = mouse_buttons;
        v.delta_x              = $signed(mouse_dx);
        v.delta_y              = $signed(mouse_dy);
        v.pointer_x            = pos_x;
        v.pointer_y            = pos_y;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        tracker_view_t want;
        tracker_view_t fresh;
        if (!rst_n) begin
            expected_views.delete();
            width_reg     = DEFAULT_WIDTH;
            height_reg    = DEFAULT_HEIGHT;
            kbd_now       = '0;
            kbd_before    = '0;
            mouse_buttons = '0;
            mouse_dx      = '0;
            mouse_dy      = '0;
            pos_x         = '0;
            pos_y         = '0;
            fail_count    = 0;
            pending       = 0;
            checked       = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                checked++;
                if (expected_views.size() == 0) begin
                    $error("result word with no report waiting");
                    fail_count++;
                end else begin
                    want = expected_views.pop_front();
                    compare_field("accepted", want.accepted, m_tuser);
                    compare_field("modifier_bits", want.modifier_bits, m_tdata[7:0]);
                    compare_field("fresh_key", want.fresh_key, m_tdata[15:8]);
                    compare_field("fresh_key_translated", want.fresh_key_translated,
                                  m_tdata[23:16]);
                    compare_field("button_bits", want.button_bits, m_tdata[31:24]);
                    compare_field("delta_x", int'(want.delta_x),
                                  int'($signed(m_tdata[39:32])));
                    compare_field("delta_y", int'(want.delta_y),
                                  int'($signed(m_tdata[47:40])));
                    compare_field("pointer_x", want.pointer_x, m_tdata[59:48]);
                    compare_field("pointer_y", want.pointer_y, m_tdata[71:60]);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  width_reg  = cfg_data;
                    CFG_SCREEN_HEIGHT: height_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                track_report(s_tuser, s_tdata[3:0], s_tdata[67:4], fresh);
                expected_views.push_back(fresh);
            end
            pending = expected_views.size();
        end
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives keyboard and mouse boot reports and screen-size writes into the
// boot report tracker under random idling on both sides; hbrt_checker
// predicts and checks every result word.
// ----------------------------------------------------------------------------
module tb;
    import hbrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 180;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [71:0]            s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [71:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_SCREEN_WIDTH;
    logic [POS_W-1:0]       cfg_data = '0;

    int          fail_count;
    int          pending;
    int          checked;
    int          idle_cycles = 0;
    logic        idle_on = 1'b1;
    logic [47:0] held_keys = '0;
    int          kbd_sent = 0;
    int          mouse_sent = 0;
    int          short_sent = 0;
    int          settings = 1;

    hid_boot_report_tracker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    hbrt_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fail_count(fail_count),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_tready <= idle_on ? ($urandom_range(99) >= 18) : 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic logic [63:0] kbd_bytes(input logic [7:0] mods, input logic [7:0] rsv,
                                              input logic [7:0] k0, input logic [7:0] k1,
                                              input logic [7:0] k2, input logic [7:0] k3,
                                              input logic [7:0] k4, input logic [7:0] k5);
        return {k5, k4, k3, k2, k1, k0, rsv, mods};
    endfunction

    function automatic logic [63:0] mse_bytes(input logic [7:0] btn, input logic [7:0] dx,
                                              input logic [7:0] dy);
        return {$urandom(), 8'($urandom()), dy, dx, btn};
    endfunction

    function automatic logic [7:0] pick_usage();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 8'h00;
        else if (r < 80)
            return 8'($urandom_range(8'h73, 8'h04));
        else if (r < 90)
            return 8'hE0 + 8'($urandom_range(7));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] pick_delta();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return 8'($urandom_range(16) - 8);
        else if (r < 80)
            return 8'($urandom_range(255));
        return $urandom_range(1) ? 8'h7F : 8'h80;
    endfunction

    function automatic logic [POS_W-1:0] pick_bound();
        case ($urandom_range(4))
            0: return '0;
            1: return 12'd1;
            2: return 12'd4095;
            3: return 12'($urandom_range(64, 2));
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_report(input logic mouse, input logic [LEN_W-1:0] len,
                               input logic [63:0] bytes);
        while (idle_on && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mouse;
        s_tdata  <= {4'h0, bytes, len};
        do @(posedge clk); while (!s_tready);
        if (!mouse && len >= KBD_MIN_LEN) begin
            kbd_sent++;
            held_keys = bytes[63:16];
        end else if (mouse && len >= MSE_MIN_LEN)
            mouse_sent++;
        else
            short_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [POS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_screen(input logic [POS_W-1:0] w, input logic [POS_W-1:0] h);
        drain_results();
        write_reg(CFG_SCREEN_WIDTH, w);
        write_reg(CFG_SCREEN_HEIGHT, h);
        settings++;
    endtask

    // one random report; returns 1 when the tracker will take it
    task automatic send_random(output logic taken);
        int          r;
        logic [63:0] bytes;
        logic        mouse;
        logic [3:0]  len;
        r = $urandom_range(99);
        if (r < 40) begin
            mouse = 1'b0;
            len   = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9)) : 4'd8;
            bytes[15:0] = 16'($urandom());
            for (int i = 0; i < 6; i++)
                bytes[16 + 8*i +: 8] = ($urandom_range(99) < 55) ?
                    held_keys[8*$urandom_range(5) +: 8] : pick_usage();
        end else if (r < 75) begin
            mouse = 1'b1;
            len   = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 4)) : 4'd3;
            bytes = mse_bytes(8'($urandom()), pick_delta(), pick_delta());
        end else begin
            mouse = 1'($urandom_range(1));
            len   = $urandom_range(1) ? 4'($urandom_range(15)) :
                                        4'($urandom_range(mouse ? 2 : 7));
            bytes = {$urandom(), $urandom()};
        end
        send_report(mouse, len, bytes);
        taken = mouse ? (len >= MSE_MIN_LEN) : (len >= KBD_MIN_LEN);
    endtask

    initial
    begin
        logic taken;
        int   n;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short reports change nothing
        send_report(1'b0, 4'd7, 64'hFFFF_FFFF_FFFF_FFFF);
        send_report(1'b1, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_report(1'b1, 4'd0, 64'h0123_4567_89AB_CDEF);
        send_report(1'b0, 4'd0, 64'h0);
        // keyboard: fresh key search, empty slots, unmapped and modifier usages
        send_report(1'b0, 4'd8, kbd_bytes(8'hFF, 8'h00, 8'h04, 8'h05, 0, 0, 0, 0));
        send_report(1'b0, 4'd8, kbd_bytes(8'h00, 8'hFF, 8'h05, 8'h04, 8'h06, 0, 0, 0));
        send_report(1'b0, 4'd8, kbd_bytes(8'h00, 8'hFF, 8'h05, 8'h04, 8'h06, 0, 0, 0));
        send_report(1'b0, 4'd8, kbd_bytes(8'h55, 8'h00, 0, 0, 0, 0, 0, 8'hE0));
        send_report(1'b0, 4'd15, kbd_bytes(8'hAA, 8'h5A, 8'h32, 8'hFF, 8'h01, 8'hE7,
                                           8'h73, 8'h74));
        send_report(1'b0, 4'd9, kbd_bytes(8'h0F, 8'hF0, 0, 0, 0, 0, 0, 0));
        send_report(1'b0, 4'd12, kbd_bytes(8'h80, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                           8'hFF, 8'hFF));
        send_report(1'b0, 4'd8, kbd_bytes(8'h01, 8'h80, 8'h01, 8'h02, 8'h03, 8'h70,
                                          8'hDF, 8'hE8));
        send_report(1'b0, 4'd8, kbd_bytes(8'h01, 8'h80, 8'hE8, 8'hDF, 8'h70, 8'h03,
                                          8'h02, 8'h01));
        // mouse: delta extremes and clamping at both ends of the default screen
        send_report(1'b1, 4'd3, mse_bytes(8'h07, 8'h7F, 8'h7F));
        send_report(1'b1, 4'd15, mse_bytes(8'hFF, 8'h80, 8'h80));
        for (int i = 0; i < 6; i++)
            send_report(1'b1, 4'd3, mse_bytes(8'($urandom()), 8'h7F, 8'h7F));
        send_report(1'b1, 4'd8, mse_bytes(8'h00, 8'h00, 8'h00));
        send_report(1'b0, 4'd7, 64'h0);

        // largest screen, walk the pointer to the far corner
        set_screen(12'd4095, 12'd4095);
        for (int i = 0; i < 34; i++)
            send_report(1'b1, 4'd3, mse_bytes(8'($urandom()), 8'h7F, 8'h7F));
        // lowered bound: position holds until the next mouse report clamps it
        set_screen(12'd10, 12'd5);
        send_report(1'b0, 4'd8, kbd_bytes(8'h02, 8'h00, 8'h2C, 0, 0, 0, 0, 0));
        send_report(1'b1, 4'd2, mse_bytes(8'h01, 8'h10, 8'h10));
        send_report(1'b1, 4'd3, mse_bytes(8'h01, 8'h00, 8'h00));
        // zero selects the default size
        set_screen(12'd0, 12'd0);
        for (int i = 0; i < 8; i++)
            send_report(1'b1, 4'd3, mse_bytes(8'h00, 8'h7F, 8'h7F));
        set_screen(12'd1, 12'd1);
        send_report(1'b1, 4'd3, mse_bytes(8'h00, 8'h7F, 8'h80));
        send_report(1'b1, 4'd3, mse_bytes(8'h00, 8'h80, 8'h7F));

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_screen(pick_bound(), pick_bound());
            idle_on = (p != 0);
            n = 0;
            while (n < PHASE_ITEMS) begin
                send_random(taken);
                if (taken)
                    n++;
            end
        end
        idle_on = 1'b1;

        drain_results();
        repeat (8) @(posedge clk);
        $display("Covered %0d keyboard, %0d mouse and %0d short reports over %0d screen sizes.",
                 kbd_sent, mouse_sent, short_sent, settings);
        $display("%0d result words checked, %0d mismatches.", checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
